// ----- src/bresenham_line_framebuffer_unit_assert.svh -----
// Assertion macros for the line frame store unit.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef BRESENHAM_LINE_FRAMEBUFFER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_FRAMEBUFFER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BLF_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define BLF_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- src/blf_pkg.sv -----
// Shared types and constants for the line frame store unit.
// Used by the controller, the datapath and the top level.
package blf_pkg;

	localparam int COORD_W = 12;
	localparam int DX_W    = 13;
	localparam int ERR_W   = 15;
	localparam int STEP_W  = 12;
	localparam int DIM_W   = 13;
	localparam int COLOR_W = 32;
	localparam int COUNT_W = 13;
	localparam int MODE_W  = 2;
	localparam int VW_W    = 10;
	localparam int VH_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 48;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd4096;
	localparam logic [VW_W-1:0] VIEW_WIDTH_RST  = 10'd320;
	localparam logic [VH_W-1:0] VIEW_HEIGHT_RST = 9'd200;

	localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd1;

	typedef struct packed {
		logic load;
		logic setup;
		logic clr_init;
		logic line_step;
		logic clr_step;
		logic plot;
		logic out_load;
		logic res_read;
		logic res_draw;
	} blf_cmd_t;

	typedef struct packed {
		logic line_last;
		logic clr_empty;
		logic clr_last;
	} blf_sts_t;

endpackage

// ----- src/bresenham_line_framebuffer_unit.sv -----
// Line frame store unit: draws Bresenham lines, clears and reads a 32-bit
// frame store. A clear of an empty view writes nothing, and an unused mode only
// returns an all-zero result. The single memory write port writes one pixel per
// cycle during a draw or a clear. Commands run one at a time; the result register
// lets the next command be taken while a result waits. Depends on blf_pkg,
// blf_ctrl, blf_datapath and the assertion header.
module bresenham_line_framebuffer_unit #(
	parameter int MAX_WIDTH  = blf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = blf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [blf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [blf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], pixel_color[79:48]
	input  logic [blf_pkg::IN_DATA_W-1:0]        s_tdata,
	// mode[1:0]
	input  logic [blf_pkg::MODE_W-1:0]           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_color[31:0], pixels_written[44:32], zero[47:45]
	output logic [blf_pkg::OUT_DATA_W-1:0]       m_tdata,
	// outside_view[0]
	output logic                                 m_tuser
);
	import blf_pkg::*;

	blf_cmd_t cmd;
	blf_sts_t sts;

	logic [COLOR_W-1:0] read_color;
	logic [COUNT_W-1:0] pixels_written;
	logic               outside_view;

	assign cfg_ready = 1'b1;

	blf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.mode    (s_tuser),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	blf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.start_x        (s_tdata[11:0]),
		.start_y        (s_tdata[23:12]),
		.end_x          (s_tdata[35:24]),
		.end_y          (s_tdata[47:36]),
		.pixel_color    (s_tdata[79:48]),
		.read_color     (read_color),
		.outside_view   (outside_view),
		.pixels_written (pixels_written)
	);

	assign m_tdata = {(OUT_DATA_W - COLOR_W - COUNT_W)'(0), pixels_written, read_color};
	assign m_tuser = outside_view;

	`include "bresenham_line_framebuffer_unit_assert.svh"

	`BLF_ASSERT_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready)
	`BLF_ASSERT_SAME(a_result_from_busy, $rose(m_tvalid), $past(!s_tready))
	`BLF_ASSERT_SAME(a_outside_zero, m_tvalid && m_tuser, m_tdata == '0)
	`BLF_ASSERT_SAME(a_plot_while_busy, cmd.plot, !s_tready)

endmodule

// ----- src/blf_ctrl.sv -----
// Command sequencer of the line frame store unit.
// Depends on blf_pkg for command and status types and mode codes.
module blf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_valid,
	output logic                      s_ready,
	input  logic [blf_pkg::MODE_W-1:0] mode,
	output logic                      m_valid,
	input  logic                      m_ready,
	input  blf_pkg::blf_sts_t         sts,
	output blf_pkg::blf_cmd_t         cmd
);
	import blf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_LINE,
		S_CLR_INIT,
		S_CLEAR,
		S_RD0,
		S_RD1,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [MODE_W-1:0]   mode_q;
	logic                m_valid_q;
	logic                out_free;

	assign out_free = !m_valid_q || m_ready;
	assign s_ready  = (state_q == S_IDLE);
	assign m_valid  = m_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && s_valid;
		cmd.setup     = (state_q == S_SETUP);
		cmd.clr_init  = (state_q == S_CLR_INIT);
		cmd.plot      = (state_q == S_LINE) || (state_q == S_CLEAR);
		cmd.line_step = (state_q == S_LINE) && !sts.line_last;
		cmd.clr_step  = (state_q == S_CLEAR);
		cmd.out_load  = (state_q == S_DONE) && out_free;
		cmd.res_read  = (mode_q == MODE_READ);
		cmd.res_draw  = (mode_q == MODE_DRAW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= MODE_DRAW;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_ready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_valid) begin
						mode_q <= mode;
						unique case (mode)
							MODE_DRAW:  state_q <= S_SETUP;
							MODE_CLEAR: state_q <= S_CLR_INIT;
							MODE_READ:  state_q <= S_RD0;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_SETUP: state_q <= S_LINE;
				S_LINE: begin
					if (sts.line_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_CLR_INIT: begin
					if (sts.clr_empty) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_DONE;
				S_DRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/blf_datapath.sv -----
// Datapath of the line frame store unit: view registers, line stepper,
// clear sweep, address stage, frame memory and result register. Uses blf_pkg.
module blf_datapath #(
	parameter int MAX_WIDTH  = blf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = blf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [blf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [blf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  blf_pkg::blf_cmd_t                   cmd,
	output blf_pkg::blf_sts_t                   sts,
	input  logic signed [blf_pkg::COORD_W-1:0]  start_x,
	input  logic signed [blf_pkg::COORD_W-1:0]  start_y,
	input  logic signed [blf_pkg::COORD_W-1:0]  end_x,
	input  logic signed [blf_pkg::COORD_W-1:0]  end_y,
	input  logic [blf_pkg::COLOR_W-1:0]         pixel_color,
	output logic [blf_pkg::COLOR_W-1:0]         read_color,
	output logic                                outside_view,
	output logic [blf_pkg::COUNT_W-1:0]         pixels_written
);
	import blf_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [VW_W-1:0]  view_width_q;
	logic [VH_W-1:0]  view_height_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;

	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [DX_W-1:0]    dx_q;
	logic signed [DX_W-1:0]    dy_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   inc_a_q;
	logic signed [ERR_W-1:0]   inc_b_q;
	logic [STEP_W-1:0]         steps_q;
	logic                      steep_q;
	logic [COLOR_W-1:0]        color_q;
	logic [COUNT_W-1:0]        count_q;

	logic signed [DX_W-1:0]  adx;
	logic signed [DX_W-1:0]  ady;
	logic signed [DX_W-1:0]  major;
	logic signed [DX_W-1:0]  minor;
	logic signed [ERR_W-1:0] minor2;
	logic signed [ERR_W-1:0] major2;
	logic                    steep;

	logic signed [COORD_W-1:0] x_adv;
	logic signed [COORD_W-1:0] y_adv;
	logic [DIM_W-1:0]          xu;
	logic [DIM_W-1:0]          yu;
	logic                      in_view;
	logic [ADDR_W-1:0]         addr;
	logic                      col_end;
	logic                      row_end;

	logic                wr_en_s1;
	logic                inside_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [COLOR_W-1:0]  rd_data_q;
	logic [COLOR_W-1:0]  mem [DEPTH];

	logic [COLOR_W-1:0]  res_color_q;
	logic                res_outside_q;
	logic [COUNT_W-1:0]  res_count_q;

	assign eff_w = (DIM_W'(view_width_q) > DIM_W'(MAX_WIDTH)) ?
		DIM_W'(MAX_WIDTH) : DIM_W'(view_width_q);
	assign eff_h = (DIM_W'(view_height_q) > DIM_W'(MAX_HEIGHT)) ?
		DIM_W'(MAX_HEIGHT) : DIM_W'(view_height_q);

	assign adx    = dx_q[DX_W-1] ? -dx_q : dx_q;
	assign ady    = dy_q[DX_W-1] ? -dy_q : dy_q;
	assign steep  = (adx <= ady);
	assign major  = steep ? ady : adx;
	assign minor  = steep ? adx : ady;
	assign minor2 = ERR_W'(minor) <<< 1;
	assign major2 = ERR_W'(major) <<< 1;

	assign x_adv = dx_q[DX_W-1] ? (x_q - COORD_W'(1)) : (x_q + COORD_W'(1));
	assign y_adv = dy_q[DX_W-1] ? (y_q - COORD_W'(1)) : (y_q + COORD_W'(1));

	assign xu      = DIM_W'($unsigned(x_q));
	assign yu      = DIM_W'($unsigned(y_q));
	assign in_view = !x_q[COORD_W-1] && !y_q[COORD_W-1] && (xu < eff_w) && (yu < eff_h);
	assign addr    = ADDR_W'(yu) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xu);
	assign col_end = ((xu + DIM_W'(1)) == eff_w);
	assign row_end = ((yu + DIM_W'(1)) == eff_h);

	assign sts.line_last = (steps_q == '0);
	assign sts.clr_empty = (eff_w == '0) || (eff_h == '0);
	assign sts.clr_last  = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= VIEW_WIDTH_RST;
			view_height_q <= VIEW_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VIEW_WIDTH:  view_width_q  <= VW_W'(cfg_data);
				REG_VIEW_HEIGHT: view_height_q <= VH_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= start_x;
			y_q     <= start_y;
			dx_q    <= DX_W'(end_x) - DX_W'(start_x);
			dy_q    <= DX_W'(end_y) - DX_W'(start_y);
			color_q <= pixel_color;
		end else if (cmd.setup) begin
			steep_q <= steep;
			steps_q <= STEP_W'(major);
			err_q   <= minor2 - ERR_W'(major);
			inc_a_q <= minor2;
			inc_b_q <= minor2 - major2;
		end else if (cmd.clr_init) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cmd.line_step) begin
			steps_q <= steps_q - STEP_W'(1);
			if (steep_q) begin
				y_q <= y_adv;
			end else begin
				x_q <= x_adv;
			end
			if (err_q[ERR_W-1]) begin
				err_q <= err_q + inc_a_q;
			end else begin
				err_q <= err_q + inc_b_q;
				if (steep_q) begin
					x_q <= x_adv;
				end else begin
					y_q <= y_adv;
				end
			end
		end else if (cmd.clr_step) begin
			if (col_end) begin
				x_q <= '0;
				y_q <= y_q + COORD_W'(1);
			end else begin
				x_q <= x_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1  <= 1'b0;
			inside_s1 <= 1'b0;
		end else begin
			wr_en_s1  <= cmd.plot && in_view;
			inside_s1 <= in_view;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[addr_s1] <= color_q;
		end
		rd_data_q <= mem[addr_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= '0;
		end else if (wr_en_s1 && (count_q != COUNT_LIMIT)) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_color_q   <= (cmd.res_read && inside_s1) ? rd_data_q : '0;
			res_outside_q <= cmd.res_read && !inside_s1;
			res_count_q   <= cmd.res_draw ? count_q : '0;
		end
	end

	assign read_color     = res_color_q;
	assign outside_view   = res_outside_q;
	assign pixels_written = res_count_q;

endmodule

// ----- bench/line_store_checker.sv -----
`timescale 1ns / 1ps
// Checker for the line frame store unit. It tracks register writes, keeps its own copy of
// the frame store, predicts each command's result and compares the output stream.
// Depends on blf_pkg.
module line_store_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [blf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [blf_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [blf_pkg::MODE_W-1:0]        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [blf_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              m_tuser,
	output int                                mismatches,
	output int                                results_seen,
	output int                                open_count
);
	import blf_pkg::*;

	localparam int STORE_W = MAX_WIDTH_DEF;
	localparam int STORE_H = MAX_HEIGHT_DEF;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               outside;
		logic [COUNT_W-1:0] count;
	} cmd_result_t;

	logic [COLOR_W-1:0] frame_copy [STORE_W*STORE_H];
	logic [VW_W-1:0]    view_w;
	logic [VH_W-1:0]    view_h;
	cmd_result_t        expected_results [$];

	function automatic int vis_w();
		return (view_w > STORE_W) ? STORE_W : int'(view_w);
	endfunction

	function automatic int vis_h();
		return (view_h > STORE_H) ? STORE_H : int'(view_h);
	endfunction

	function automatic bit on_screen(int x, int y);
		return x >= 0 && y >= 0 && x < vis_w() && y < vis_h();
	endfunction

	function automatic int put_pixel(int x, int y, logic [COLOR_W-1:0] c);
		if (!on_screen(x, y))
			return 0;
		frame_copy[y * STORE_W + x] = c;
		return 1;
	endfunction

	function automatic int trace_line(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] c);
		int adx, ady, stx, sty, x, y, err, hits;
		adx = (x1 < x0) ? x0 - x1 : x1 - x0;
		ady = (y1 < y0) ? y0 - y1 : y1 - y0;
		stx = (x1 < x0) ? -1 : 1;
		sty = (y1 < y0) ? -1 : 1;
		x = x0;
		y = y0;
		hits = put_pixel(x, y, c);
		// ties make y the major axis
		if (adx > ady) begin
			err = 2 * ady - adx;
			repeat (adx) begin
				x += stx;
				if (err < 0) begin
					err += 2 * ady;
				end else begin
					y += sty;
					err += 2 * ady - 2 * adx;
				end
				hits += put_pixel(x, y, c);
			end
		end else begin
			err = 2 * adx - ady;
			repeat (ady) begin
				y += sty;
				if (err < 0) begin
					err += 2 * adx;
				end else begin
					x += stx;
					err += 2 * adx - 2 * ady;
				end
				hits += put_pixel(x, y, c);
			end
		end
		return (hits > int'(COUNT_LIMIT)) ? int'(COUNT_LIMIT) : hits;
	endfunction

	function automatic void fill_view(logic [COLOR_W-1:0] c);
		for (int r = 0; r < vis_h(); r++)
			for (int k = 0; k < vis_w(); k++)
				frame_copy[r * STORE_W + k] = c;
	endfunction

	function automatic cmd_result_t predict_command(logic [MODE_W-1:0] mode,
			logic [IN_DATA_W-1:0] d);
		cmd_result_t r;
		int sx, sy, ex, ey;
		sx = int'($signed(d[11:0]));
		sy = int'($signed(d[23:12]));
		ex = int'($signed(d[35:24]));
		ey = int'($signed(d[47:36]));
		r = '0;
		case (mode)
			MODE_DRAW: begin
				r.count = COUNT_W'(trace_line(sx, sy, ex, ey, d[79:48]));
			end
			MODE_CLEAR: begin
				fill_view(d[79:48]);
			end
			MODE_READ: begin
				if (on_screen(sx, sy))
					r.color = frame_copy[sy * STORE_W + sx];
				else
					r.outside = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cmd_result_t want;
		int errs;
		if (!arst_n) begin
			view_w = VIEW_WIDTH_RST;
			view_h = VIEW_HEIGHT_RST;
			expected_results.delete();
			mismatches   <= 0;
			results_seen <= 0;
			open_count   <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VIEW_WIDTH:  view_w = cfg_data[VW_W-1:0];
					REG_VIEW_HEIGHT: view_h = cfg_data[VH_W-1:0];
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result with no command pending: tdata %h tuser %b", m_tdata, m_tuser);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.color) begin
						$error("read_color: expected %h, got %h", want.color, m_tdata[31:0]);
						errs++;
					end
					if (m_tuser !== want.outside) begin
						$error("outside_view: expected %b, got %b", want.outside, m_tuser);
						errs++;
					end
					if (m_tdata[44:32] !== want.count) begin
						$error("pixels_written: expected %0d, got %0d", want.count,
							m_tdata[44:32]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_command(s_tuser, s_tdata));
			mismatches <= mismatches + errs;
			open_count <= expected_results.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the line frame store testbench: clock, reset, command and register stimulus,
// output back-pressure and the verdict. Depends on blf_pkg, line_store_checker and the unit.
module tb_top;
	import blf_pkg::*;

	localparam logic [MODE_W-1:0]    CMD_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	int mismatches;
	int results_seen;
	int open_count;
	int sent;
	int burst_left;
	int squeeze_req;
	int vw_eff;
	int vh_eff;

	bresenham_line_framebuffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	line_store_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.open_count   (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("bresenham_line_framebuffer_unit test failed");
		$finish;
	end

	// Output back-pressure: random stall segments, plus a long hold-off on request.
	initial begin : receiver
		int seen, hold_left, seg_left, kind;
		m_tready = 1'b0;
		seen = 0;
		hold_left = 0;
		seg_left = 0;
		kind = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (squeeze_req != seen) begin
				seen = squeeze_req;
				hold_left = 400;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					kind = $urandom_range(0, 3);
					seg_left = $urandom_range(1, 40);
				end
				seg_left--;
				case (kind)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic push_command(input logic [MODE_W-1:0] mode, input int sx, input int sy,
			input int ex, input int ey, input logic [COLOR_W-1:0] color);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {color, ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_VIEW_WIDTH:  vw_eff = (data[VW_W-1:0] > 512) ? 512 : int'(data[VW_W-1:0]);
			REG_VIEW_HEIGHT: vh_eff = (data[VH_W-1:0] > 256) ? 256 : int'(data[VH_W-1:0]);
			default: begin
			end
		endcase
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_seen != sent) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int any_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	task automatic random_commands(input int count, input bit clears_ok);
		int pick, sx, sy, ex, ey;
		logic [MODE_W-1:0] mode;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			sx = int'($urandom_range(0, vw_eff + 15)) - 8;
			sy = int'($urandom_range(0, vh_eff + 15)) - 8;
			ex = sx + int'($urandom_range(0, 96)) - 48;
			ey = sy + int'($urandom_range(0, 96)) - 48;
			mode = MODE_DRAW;
			if (pick < 44) begin
				if ($urandom_range(0, 9) == 0) begin
					sx = any_coord();
					sy = any_coord();
					ex = any_coord();
					ey = any_coord();
				end else if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: ey = sy;
						1: ex = sx;
						2: begin
							ex = sx;
							ey = sy;
						end
						default: ey = sy + ((ex > sx) ? ex - sx : sx - ex);
					endcase
				end
			end else if (pick < 88) begin
				mode = MODE_READ;
				if (vw_eff > 0 && vh_eff > 0 && $urandom_range(0, 4) != 0) begin
					sx = $urandom_range(0, vw_eff - 1);
					sy = $urandom_range(0, vh_eff - 1);
				end else if ($urandom_range(0, 1) == 0) begin
					sx = any_coord();
					sy = any_coord();
				end
			end else if (pick < 94 && clears_ok) begin
				mode = MODE_CLEAR;
			end else if (pick < 97) begin
				mode = CMD_UNUSED;
				sx = any_coord();
				sy = any_coord();
				ex = any_coord();
				ey = any_coord();
			end
			push_command(mode, sx, sy, ex, ey, $urandom());
		end
	endtask

	task automatic directed_commands();
		push_command(MODE_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF);
		push_command(MODE_DRAW, 10, 10, 10, 10, 32'h1234_5678);
		push_command(MODE_DRAW, 0, 0, 20, 5, 32'hA5A5_0001);
		push_command(MODE_DRAW, 40, 30, 15, 22, 32'hA5A5_0002);
		push_command(MODE_DRAW, 50, 10, 53, 40, 32'hA5A5_0003);
		push_command(MODE_DRAW, 70, 60, 62, 20, 32'hA5A5_0004);
		push_command(MODE_DRAW, 100, 100, 110, 110, 32'hA5A5_0005);
		push_command(MODE_DRAW, 130, 100, 120, 110, 32'hA5A5_0006);
		push_command(MODE_DRAW, -2048, -2048, 2047, 2047, 32'h0F0F_0F0F);
		push_command(MODE_DRAW, -2048, 2047, 2047, -2048, 32'hF0F0_F0F0);
		push_command(MODE_DRAW, 2047, 5, -2048, 5, 32'h5555_AAAA);
		push_command(MODE_DRAW, 319, 199, 330, 205, 32'h0000_0001);
		push_command(MODE_READ, 0, 0, 0, 0, 32'h0);
		push_command(MODE_READ, 10, 10, 0, 0, 32'h0);
		push_command(MODE_READ, 319, 199, 0, 0, 32'h0);
		push_command(MODE_READ, 320, 0, 0, 0, 32'h0);
		push_command(MODE_READ, 0, 200, 0, 0, 32'h0);
		push_command(MODE_READ, -1, 0, 0, 0, 32'h0);
		push_command(MODE_READ, -2048, -2048, 0, 0, 32'h0);
		push_command(MODE_READ, 2047, 2047, 0, 0, 32'h0);
		push_command(CMD_UNUSED, -1, -1, -1, -1, 32'hFFFF_FFFF);
		push_command(MODE_CLEAR, 0, 0, 0, 0, 32'h0000_0000);
		push_command(MODE_READ, 5, 5, 0, 0, 32'h0);
		push_command(MODE_DRAW, 5, 5, 5, 5, 32'hDEAD_BEEF);
		push_command(MODE_READ, 5, 5, 0, 0, 32'h0);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input int count, input bit clears_ok);
		settle();
		write_reg(REG_VIEW_WIDTH, w);
		write_reg(REG_VIEW_HEIGHT, h);
		random_commands(count, clears_ok);
	endtask

	initial begin : stimulus
		int waited;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		sent        = 0;
		burst_left  = 0;
		squeeze_req = 0;
		vw_eff      = int'(VIEW_WIDTH_RST);
		vh_eff      = int'(VIEW_HEIGHT_RST);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_commands();
		random_commands(120, 1'b0);

		// oversized view, then fill the whole store once
		run_phase(10'h3FF, 10'h3FF, 0, 1'b0);
		write_reg(REG_SPARE_A, 10'h2AA);
		write_reg(REG_SPARE_B, 10'h155);
		push_command(MODE_CLEAR, 0, 0, 0, 0, $urandom());
		random_commands(150, 1'b0);

		run_phase(10'd512, 10'd256, 0, 1'b0);
		squeeze_req <= squeeze_req + 1;
		random_commands(100, 1'b0);

		run_phase(10'd1, 10'd1, 80, 1'b1);
		run_phase(10'd0, 10'd100, 60, 1'b1);
		run_phase(10'd600, 10'd0, 60, 1'b1);
		run_phase(10'd37, 10'd23, 120, 1'b1);
		run_phase(10'd200, 10'd256, 80, 1'b0);
		run_phase(10'd16, 10'd200, 80, 1'b1);

		s_tvalid <= 1'b0;
		waited = 0;
		while (results_seen < sent && waited < 300000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (mismatches == 0 && open_count == 0)
			$display("bresenham_line_framebuffer_unit test passed");
		else
			$display("bresenham_line_framebuffer_unit test failed");
		$finish;
	end

endmodule

// ----- bresenham_line_framebuffer_unit.f -----
+incdir+src
src/blf_pkg.sv
src/blf_ctrl.sv
src/blf_datapath.sv
src/bresenham_line_framebuffer_unit.sv
bench/line_store_checker.sv
bench/tb_top.sv
